// ----- rtl/udec_pkg.sv -----
package udec_pkg;

  // byte store: five pending bytes plus the incoming one
  localparam int BufDepth = 6;
  localparam int CntW     = 3;
  localparam int CpW      = 31;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take the input beat into the byte store
    logic advance;    // consume the front of the store, capture its result
    logic push;       // move the held result into the output register
    logic push_last;  // the pushed result closes the current item
    logic drop_hold;  // the held result is gone
  } udec_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic emit;        // decode step yields a result
    logic done;        // store empty or holds only an unfinished sequence
    logic hold_valid;  // a result waits in the hold register
    logic out_free;    // output register can take a result this cycle
  } udec_stat_t;

endpackage

// ----- rtl/utf8_stream_decoder_31bit.sv -----
// UTF-8 stream decoder for the original one- to six-byte forms (31-bit values).
// Input channel in_valid/in_ready carries one beat: data_byte, or flush to
// release the bytes of an unfinished sequence as raw invalid bytes.
// Output channel out_valid/out_ready carries one result per beat: code_point,
// invalid (raw byte outside a valid sequence) and last (final result of the
// input beat). An input beat yields zero to six results.
// Timing: a beat is taken only while the decoder is idle. One decode step runs
// per cycle while the output does not stall, and each step consumes the front
// of the byte store, resolving one lead byte. A step's result passes through
// the hold register into the output register; further results follow one per
// cycle while the output does not stall.
// Reset (rst, synchronous) empties the byte store and drops any pending result.
// When the receiver stalls, the output register holds its result, the decode
// step waits and in_ready stays low until the item's last result has moved into
// the output register; a new beat can be taken while it still waits there.
module utf8_stream_decoder_31bit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        flush,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] code_point,
  output logic        invalid,
  output logic        last
);
  import udec_pkg::*;

  udec_cmd_t  cmd;
  udec_stat_t stat;

  // sequencing of load, decode steps and result hand-off
  udec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // byte store, decode step and result registers
  udec_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .flush      (flush),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .code_point (code_point),
    .invalid    (invalid),
    .last       (last)
  );

endmodule

// ----- rtl/udec_datapath.sv -----
module udec_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             data_byte,
  input  logic                   flush,
  input  udec_pkg::udec_cmd_t    cmd,
  output udec_pkg::udec_stat_t   stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [30:0]            code_point,
  output logic                   invalid,
  output logic                   last
);
  import udec_pkg::*;

  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] LeadFive  = 8'hF8;
  localparam logic [7:0] LeadSix   = 8'hFC;
  localparam logic [7:0] LeadBad   = 8'hFE;
  localparam logic [1:0] ContTag   = 2'b10;

  // sequence length announced by a lead byte, zero when it cannot lead
  function automatic logic [CntW-1:0] seq_len(input logic [7:0] b);
    logic [CntW-1:0] n;
    if (b < LeadTwo)        n = CntW'(0);
    else if (b < LeadThree) n = CntW'(2);
    else if (b < LeadFour)  n = CntW'(3);
    else if (b < LeadFive)  n = CntW'(4);
    else if (b < LeadSix)   n = CntW'(5);
    else if (b < LeadBad)   n = CntW'(6);
    else                    n = CntW'(0);
    return n;
  endfunction

  logic [BufDepth-1:0][7:0] pend;
  logic [BufDepth-1:0][7:0] pend_shifted;
  logic [CntW-1:0]          cnt;
  logic                     flush_mode;
  logic                     hold_valid;
  logic [CpW-1:0]           hold_cp;
  logic                     hold_inv;

  logic [7:0]      lead;
  logic [CntW-1:0] need;
  logic            bad;
  logic            short_seq;
  logic            overlong;
  logic [CpW-1:0]  value;
  logic [CpW-1:0]  least;
  logic [CpW-1:0]  step_cp;
  logic            step_inv;
  logic [CntW-1:0] shift;
  logic            stop;

  // one decode step on the front of the byte store
  always_comb begin
    lead = pend[0];
    need = seq_len(lead);
    bad  = 1'b0;
    for (int i = 1; i < BufDepth; i++) begin
      if ((CntW'(i) < need) && (CntW'(i) < cnt) && (pend[i][7:6] != ContTag)) begin
        bad = 1'b1;
      end
    end
    short_seq = cnt < need;
    unique case (need)
      3'd2: begin
        value = {20'b0, lead[4:0], pend[1][5:0]};
        least = 31'h80;
      end
      3'd3: begin
        value = {15'b0, lead[3:0], pend[1][5:0], pend[2][5:0]};
        least = 31'h800;
      end
      3'd4: begin
        value = {10'b0, lead[2:0], pend[1][5:0], pend[2][5:0], pend[3][5:0]};
        least = 31'h10000;
      end
      3'd5: begin
        value = {5'b0, lead[1:0], pend[1][5:0], pend[2][5:0], pend[3][5:0],
                 pend[4][5:0]};
        least = 31'h200000;
      end
      3'd6: begin
        value = {lead[0], pend[1][5:0], pend[2][5:0], pend[3][5:0], pend[4][5:0],
                 pend[5][5:0]};
        least = 31'h4000000;
      end
      default: begin
        value = '0;
        least = '0;
      end
    endcase
    overlong = value < least;

    // default outcome: front byte leaves as a raw invalid byte
    step_cp  = {23'b0, lead};
    step_inv = 1'b1;
    shift    = CntW'(1);
    stop     = 1'b0;
    if (cnt == '0) begin
      stop = 1'b1;
    end else if (flush_mode) begin
      step_inv = 1'b1;
    end else if (!lead[7]) begin
      step_inv = 1'b0;
    end else if ((need == '0) || bad) begin
      step_inv = 1'b1;
    end else if (short_seq) begin
      stop = 1'b1;
    end else if (!overlong) begin
      step_cp  = value;
      step_inv = 1'b0;
      shift    = need;
    end
  end

  assign pend_shifted = pend >> {shift, 3'b000};

  assign stat.emit       = !stop;
  assign stat.done       = stop;
  assign stat.hold_valid = hold_valid;
  assign stat.out_free   = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      flush_mode <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (flush) begin
          flush_mode <= 1'b1;
        end else begin
          flush_mode <= 1'b0;
          cnt        <= cnt + CntW'(1);
        end
      end else if (cmd.advance) begin
        cnt <= cnt - shift;
      end
      if (cmd.advance) begin
        hold_valid <= 1'b1;
      end else if (cmd.drop_hold) begin
        hold_valid <= 1'b0;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // byte store, hold and output payload
  always_ff @(posedge clk) begin
    if (cmd.load && !flush) begin
      pend[cnt] <= data_byte;
    end else if (cmd.advance) begin
      pend <= pend_shifted;
    end
    if (cmd.advance) begin
      hold_cp  <= step_cp;
      hold_inv <= step_inv;
    end
    if (cmd.push) begin
      code_point <= hold_cp;
      invalid    <= hold_inv;
      last       <= cmd.push_last;
    end
  end

  // store never overfills
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntW'(BufDepth))
    else $error("byte store count out of range");

  // flushed bytes always leave as raw bytes
  a_flush_raw: assert property (@(posedge clk) disable iff (rst)
    (cmd.advance && flush_mode) |=> hold_inv)
    else $error("flushed byte not marked invalid");

  // a pushed result is offered at the output
  a_push_out: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> out_valid)
    else $error("pushed result not presented");

endmodule

// ----- rtl/udec_ctrl.sv -----
module udec_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  udec_pkg::udec_stat_t  stat,
  output udec_pkg::udec_cmd_t   cmd
);
  import udec_pkg::*;

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t state;
  logic   go_emit;
  logic   go_done;

  assign in_ready = (state == IDLE);

  // a step may retire only if the held result can move on
  always_comb begin
    go_emit = (state == SCAN) && stat.emit && (!stat.hold_valid || stat.out_free);
    go_done = (state == SCAN) && stat.done && (!stat.hold_valid || stat.out_free);
    cmd.load      = in_valid && in_ready;
    cmd.advance   = go_emit;
    cmd.push      = (go_emit || go_done) && stat.hold_valid;
    cmd.push_last = go_done;
    cmd.drop_hold = go_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) state <= SCAN;
        end
        SCAN: begin
          if (go_done) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // closing result ends the item
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.push_last |=> (state == IDLE))
    else $error("controller still busy after closing result");

  // no beat taken while a step is in flight
  a_no_load_scan: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> !cmd.load)
    else $error("input beat taken during decode");

  // a result is pushed only into a free output register
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> stat.out_free)
    else $error("result pushed over a waiting output beat");

endmodule
